// File: hw/rtl/bpvs_pkg.sv
// shared types, constants and helpers for the blinn-phong vertex shader
`timescale 1ns / 1ps

package bpvs_pkg;

    localparam logic [1:0] REG_AMBIENT   = 2'd0;
    localparam logic [1:0] REG_DIFFUSE   = 2'd1;
    localparam logic [1:0] REG_SPECULAR  = 2'd2;
    localparam logic [1:0] REG_SHININESS = 2'd3;

    localparam logic [7:0]  SHININESS_RESET = 8'd1;
    localparam logic [23:0] SUM_MAX         = 24'hFFFFFF;
    localparam logic [41:0] POW_CAP         = 42'h100_0000_0000;
    localparam logic [41:0] Q16_ONE         = 42'd65536;

    typedef struct packed {
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] lamp_x;
        logic signed [31:0] lamp_y;
        logic signed [31:0] lamp_z;
        logic [47:0]        lamp_color;
        logic               last_light;
    } in_word_t;

    typedef struct packed {
        logic [23:0] red_out;
        logic [23:0] green_out;
        logic [23:0] blue_out;
    } out_word_t;

    typedef struct packed {
        logic [47:0] ambient_coeffs;
        logic [47:0] diffuse_coeffs;
        logic [47:0] specular_coeffs;
        logic [7:0]  shininess;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic signed [32:0] lx;
        logic signed [32:0] ly;
        logic signed [32:0] lz;
        logic signed [32:0] ex;
        logic signed [32:0] ey;
        logic signed [32:0] ez;
        logic [47:0]        color;
        logic               last;
    } item_t;

    typedef struct packed {
        logic busy;
        logic pop;
    } back_status_t;

    function automatic logic [15:0] chan16(input logic [47:0] packed_val, input logic [1:0] k);
        logic [15:0] res;
        unique case (k)
            2'd0:    res = packed_val[47:32];
            2'd1:    res = packed_val[31:16];
            default: res = packed_val[15:0];
        endcase
        return res;
    endfunction

endpackage

// File: hw/rtl/bpvs_front.sv
// front end: accepts words, forms light and eye vectors, two-entry queue to the back end
`timescale 1ns / 1ps

module bpvs_front
    import bpvs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_word_t in_word,
    output logic     item_valid,
    output item_t    item,
    input  logic     pop
);

    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    item_t      slot_reg [2];
    item_t      fresh;
    logic       push;

    assign in_stall   = (count_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign item_valid = (count_reg != 2'd0);
    assign item       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        fresh.nx    = in_word.normal_x;
        fresh.ny    = in_word.normal_y;
        fresh.nz    = in_word.normal_z;
        fresh.lx    = {in_word.lamp_x[31], in_word.lamp_x}
                    - {in_word.point_x[31], in_word.point_x};
        fresh.ly    = {in_word.lamp_y[31], in_word.lamp_y}
                    - {in_word.point_y[31], in_word.point_y};
        fresh.lz    = {in_word.lamp_z[31], in_word.lamp_z}
                    - {in_word.point_z[31], in_word.point_z};
        fresh.ex    = 33'd0 - {in_word.point_x[31], in_word.point_x};
        fresh.ey    = 33'd0 - {in_word.point_y[31], in_word.point_y};
        fresh.ez    = 33'd0 - {in_word.point_z[31], in_word.point_z};
        fresh.color = in_word.lamp_color;
        fresh.last  = in_word.last_light;
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= fresh;
        end
    end

endmodule

// File: hw/rtl/bpvs_back.sv
// back end: sequencer over one shared multiplier, root and divide steps, color sums
`timescale 1ns / 1ps

module bpvs_back
    import bpvs_pkg::*;
#(
    parameter int EXPONENT_BITS = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  logic         item_valid,
    input  item_t        item,
    output back_status_t status,
    output logic         out_valid,
    input  logic         out_stall,
    output out_word_t    out_word
);

    localparam int ECW = $clog2(EXPONENT_BITS + 1);

    localparam logic [32:0] M_HIGH = 33'h0_4000_0000;
    localparam logic [32:0] M_LOW  = 33'h0_2000_0000;
    localparam logic [32:0] M_FAR  = 33'h0_0040_0000;

    typedef enum logic [14:0] {
        ST_IDLE   = 15'h0001,
        ST_ABS    = 15'h0002,
        ST_NORM   = 15'h0004,
        ST_SQ     = 15'h0008,
        ST_ROOT   = 15'h0010,
        ST_DIV0   = 15'h0020,
        ST_DIV    = 15'h0040,
        ST_UDONE  = 15'h0080,
        ST_DOT    = 15'h0100,
        ST_AMB    = 15'h0200,
        ST_KD     = 15'h0400,
        ST_KS     = 15'h0800,
        ST_WMUL   = 15'h1000,
        ST_ADD    = 15'h2000,
        ST_FINISH = 15'h4000
    } state_t;

    typedef enum logic [1:0] {
        PASS_L,
        PASS_E,
        PASS_H
    } pass_t;

    typedef enum logic [1:0] {
        OP_SQ,
        OP_BASE,
        OP_DIF,
        OP_SPE
    } op_t;

    state_t state_reg, state_next;
    pass_t  pass_reg, pass_next;
    op_t    op_reg, op_next;
    logic [1:0]     k_reg, k_next;
    logic [4:0]     cnt_reg, cnt_next;
    logic [1:0]     j_reg, j_next;
    logic [ECW-1:0] ecnt_reg, ecnt_next;
    logic           out_valid_reg, out_valid_next;
    logic [23:0]    sum_reg [3];
    logic [23:0]    sum_next [3];

    logic signed [32:0] vec_reg [3];
    logic signed [32:0] vec_next [3];
    logic signed [32:0] te_reg [3];
    logic signed [32:0] te_next [3];
    logic [32:0]        mag_reg [3];
    logic [32:0]        mag_next [3];
    logic signed [31:0] n_reg [3];
    logic signed [31:0] n_next [3];
    logic signed [31:0] uvec_reg [3];
    logic signed [31:0] uvec_next [3];
    logic signed [31:0] lu_reg [3];
    logic signed [31:0] lu_next [3];
    logic signed [31:0] eu_reg [3];
    logic signed [31:0] eu_next [3];
    logic signed [31:0] hu_reg [3];
    logic signed [31:0] hu_next [3];

    logic [32:0]        m_reg, m_next;
    logic [61:0]        sq_reg, sq_next;
    logic [61:0]        rem_reg, rem_next;
    logic [61:0]        res_reg, res_next;
    logic [30:0]        len_reg, len_next;
    logic [31:0]        dr_reg, dr_next;
    logic [30:0]        q_reg, q_next;
    logic signed [35:0] dacc_reg, dacc_next;
    logic [34:0]        dot_reg, dot_next;
    logic               lit_reg, lit_next;
    logic [41:0]        base_reg, base_next;
    logic [41:0]        pr_reg, pr_next;
    logic [EXPONENT_BITS-1:0] exp_reg, exp_next;
    logic [41:0]        wa_reg, wa_next;
    logic [41:0]        wb_reg, wb_next;
    logic [83:0]        acc_reg, acc_next;
    logic [17:0]        amb_reg, amb_next;
    logic [16:0]        kdc_reg, kdc_next;
    logic [16:0]        ksc_reg, ksc_next;
    logic [42:0]        dif_reg, dif_next;
    logic [42:0]        spe_reg, spe_next;
    logic [47:0]        color_reg, color_next;
    logic               last_reg, last_next;
    out_word_t          out_word_reg, out_word_next;

    logic               pop;
    logic [32:0]        abs_v [3];
    logic [32:0]        abs_max;
    logic signed [31:0] usel;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic [6:0]         wsh;
    logic [83:0]        wfull;
    logic [41:0]        wsat;
    logic [61:0]        sq_sum;
    logic [61:0]        bitv;
    logic [61:0]        cmpv;
    logic [31:0]        r2;
    logic [30:0]        q_step;
    logic signed [35:0] dterm;
    logic signed [35:0] dsum;
    logic [44:0]        tsum;

    assign status.busy  = (state_reg != ST_IDLE);
    assign status.pop   = pop;
    assign out_valid    = out_valid_reg;
    assign out_word     = out_word_reg;

    // magnitudes and largest component
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            abs_v[i] = (vec_reg[i] < 0) ? 33'(-vec_reg[i]) : 33'(vec_reg[i]);
        end
        abs_max = abs_v[0];
        if (abs_v[1] > abs_max)
        begin
            abs_max = abs_v[1];
        end
        if (abs_v[2] > abs_max)
        begin
            abs_max = abs_v[2];
        end
    end

    // shared multiplier
    always_comb
    begin
        usel  = (pass_reg == PASS_H) ? hu_reg[k_reg] : lu_reg[k_reg];
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SQ:
            begin
                mul_a = mag_reg[k_reg];
                mul_b = mag_reg[k_reg];
            end
            ST_DOT:
            begin
                mul_a = {n_reg[k_reg][31], n_reg[k_reg]};
                mul_b = {usel[31], usel};
            end
            ST_AMB:
            begin
                mul_a = {17'd0, chan16(cfg.ambient_coeffs, k_reg)};
                mul_b = {17'd0, chan16(color_reg, k_reg)};
            end
            ST_KD:
            begin
                mul_a = {17'd0, chan16(cfg.diffuse_coeffs, k_reg)};
                mul_b = {17'd0, chan16(color_reg, k_reg)};
            end
            ST_KS:
            begin
                mul_a = {17'd0, chan16(cfg.specular_coeffs, k_reg)};
                mul_b = {17'd0, chan16(color_reg, k_reg)};
            end
            ST_WMUL:
            begin
                mul_a = {12'd0, j_reg[1] ? wa_reg[41:21] : wa_reg[20:0]};
                mul_b = {12'd0, j_reg[0] ? wb_reg[41:21] : wb_reg[20:0]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb
    begin
        wsh    = (j_reg == 2'd0) ? 7'd0 : ((j_reg == 2'd3) ? 7'd42 : 7'd21);
        wfull  = acc_reg + (84'(prod[41:0]) << wsh);
        wsat   = (wfull[83:16] > 68'(POW_CAP)) ? POW_CAP : wfull[57:16];
        sq_sum = sq_reg + 62'(prod[59:0]);
        bitv   = 62'd1 << (6'd60 - {cnt_reg, 1'b0});
        cmpv   = res_reg + bitv;
        r2     = {dr_reg[30:0], 1'b0};
        dterm  = 36'(prod >>> 30);
        dsum   = dacc_reg + dterm;
        tsum   = 45'(sum_reg[k_reg]) + 45'(amb_reg) + 45'(dif_reg) + 45'(spe_reg);
        q_step = (r2 >= {1'b0, len_reg}) ? {q_reg[29:0], 1'b1} : {q_reg[29:0], 1'b0};
    end

    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        op_next        = op_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        j_next         = j_reg;
        ecnt_next      = ecnt_reg;
        out_valid_next = out_valid_reg;
        m_next         = m_reg;
        sq_next        = sq_reg;
        rem_next       = rem_reg;
        res_next       = res_reg;
        len_next       = len_reg;
        dr_next        = dr_reg;
        q_next         = q_reg;
        dacc_next      = dacc_reg;
        dot_next       = dot_reg;
        lit_next       = lit_reg;
        base_next      = base_reg;
        pr_next        = pr_reg;
        exp_next       = exp_reg;
        wa_next        = wa_reg;
        wb_next        = wb_reg;
        acc_next       = acc_reg;
        amb_next       = amb_reg;
        kdc_next       = kdc_reg;
        ksc_next       = ksc_reg;
        dif_next       = dif_reg;
        spe_next       = spe_reg;
        color_next     = color_reg;
        last_next      = last_reg;
        out_word_next  = out_word_reg;
        pop            = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            sum_next[i]  = sum_reg[i];
            vec_next[i]  = vec_reg[i];
            te_next[i]   = te_reg[i];
            mag_next[i]  = mag_reg[i];
            n_next[i]    = n_reg[i];
            uvec_next[i] = uvec_reg[i];
            lu_next[i]   = lu_reg[i];
            eu_next[i]   = eu_reg[i];
            hu_next[i]   = hu_reg[i];
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    pop         = 1'b1;
                    n_next[0]   = item.nx;
                    n_next[1]   = item.ny;
                    n_next[2]   = item.nz;
                    vec_next[0] = item.lx;
                    vec_next[1] = item.ly;
                    vec_next[2] = item.lz;
                    te_next[0]  = item.ex;
                    te_next[1]  = item.ey;
                    te_next[2]  = item.ez;
                    color_next  = item.color;
                    last_next   = item.last;
                    pass_next   = PASS_L;
                    state_next  = ST_ABS;
                end
            end
            ST_ABS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag_next[i] = abs_v[i];
                end
                m_next = abs_max;
                if (abs_max == 33'd0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        uvec_next[i] = '0;
                    end
                    state_next = ST_UDONE;
                end
                else
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                priority if (m_reg >= M_HIGH)
                begin
                    m_next = m_reg >> 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = mag_reg[i] >> 1;
                    end
                end
                else if (m_reg < M_FAR)
                begin
                    m_next = m_reg << 8;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = mag_reg[i] << 8;
                    end
                end
                else if (m_reg < M_LOW)
                begin
                    m_next = m_reg << 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = mag_reg[i] << 1;
                    end
                end
                else
                begin
                    sq_next    = '0;
                    k_next     = 2'd0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (k_reg == 2'd2)
                begin
                    rem_next   = sq_sum;
                    res_next   = '0;
                    cnt_next   = 5'd0;
                    state_next = ST_ROOT;
                end
                else
                begin
                    sq_next = sq_sum;
                    k_next  = k_reg + 2'd1;
                end
            end
            ST_ROOT:
            begin
                if (rem_reg >= cmpv)
                begin
                    rem_next = rem_reg - cmpv;
                    res_next = (res_reg >> 1) + bitv;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd30)
                begin
                    len_next   = res_next[30:0];
                    k_next     = 2'd0;
                    state_next = ST_DIV0;
                end
            end
            ST_DIV0:
            begin
                if (mag_reg[k_reg] >= {2'b00, len_reg})
                begin
                    q_next  = 31'd1;
                    dr_next = 32'(mag_reg[k_reg] - {2'b00, len_reg});
                end
                else
                begin
                    q_next  = 31'd0;
                    dr_next = 32'(mag_reg[k_reg]);
                end
                cnt_next   = 5'd0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (r2 >= {1'b0, len_reg})
                begin
                    dr_next = r2 - {1'b0, len_reg};
                end
                else
                begin
                    dr_next = r2;
                end
                q_next   = q_step;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd29)
                begin
                    uvec_next[k_reg] = (vec_reg[k_reg] < 0) ? -$signed({1'b0, q_step})
                                                            : $signed({1'b0, q_step});
                    if (k_reg == 2'd2)
                    begin
                        state_next = ST_UDONE;
                    end
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = ST_DIV0;
                    end
                end
            end
            ST_UDONE:
            begin
                k_next    = 2'd0;
                dacc_next = '0;
                unique case (pass_reg)
                    PASS_L:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            lu_next[i]  = uvec_reg[i];
                            vec_next[i] = te_reg[i];
                        end
                        pass_next  = PASS_E;
                        state_next = ST_ABS;
                    end
                    PASS_E:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            eu_next[i] = uvec_reg[i];
                        end
                        state_next = ST_DOT;
                    end
                    default:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            hu_next[i] = uvec_reg[i];
                        end
                        state_next = ST_DOT;
                    end
                endcase
            end
            ST_DOT:
            begin
                if (k_reg == 2'd2)
                begin
                    k_next = 2'd0;
                    if (pass_reg == PASS_H)
                    begin
                        base_next  = (dsum < 0) ? '0 : 42'(dsum[34:0]);
                        pr_next    = Q16_ONE;
                        wa_next    = Q16_ONE;
                        wb_next    = Q16_ONE;
                        acc_next   = '0;
                        j_next     = 2'd0;
                        op_next    = OP_SQ;
                        exp_next   = EXPONENT_BITS'(cfg.shininess);
                        ecnt_next  = ECW'(EXPONENT_BITS);
                        state_next = ST_WMUL;
                    end
                    else if (dsum < 0)
                    begin
                        lit_next   = 1'b0;
                        state_next = ST_AMB;
                    end
                    else
                    begin
                        lit_next = 1'b1;
                        dot_next = dsum[34:0];
                        for (int i = 0; i < 3; i++)
                        begin
                            vec_next[i] = 33'(lu_reg[i]) + 33'(eu_reg[i]);
                        end
                        pass_next  = PASS_H;
                        state_next = ST_ABS;
                    end
                end
                else
                begin
                    dacc_next = dsum;
                    k_next    = k_reg + 2'd1;
                end
            end
            ST_WMUL:
            begin
                if (j_reg != 2'd3)
                begin
                    acc_next = wfull;
                    j_next   = j_reg + 2'd1;
                end
                else
                begin
                    acc_next = '0;
                    j_next   = 2'd0;
                    unique case (op_reg)
                        OP_SQ, OP_BASE:
                        begin
                            pr_next = wsat;
                            if (op_reg == OP_SQ && exp_reg[EXPONENT_BITS-1])
                            begin
                                wa_next = wsat;
                                wb_next = base_reg;
                                op_next = OP_BASE;
                            end
                            else
                            begin
                                exp_next  = exp_reg << 1;
                                ecnt_next = ecnt_reg - ECW'(1);
                                if (ecnt_reg == ECW'(1))
                                begin
                                    k_next     = 2'd0;
                                    state_next = ST_AMB;
                                end
                                else
                                begin
                                    wa_next = wsat;
                                    wb_next = wsat;
                                    op_next = OP_SQ;
                                end
                            end
                        end
                        OP_DIF:
                        begin
                            dif_next = wfull[57:15];
                            wa_next  = 42'(ksc_reg);
                            wb_next  = pr_reg;
                            op_next  = OP_SPE;
                        end
                        default:
                        begin
                            spe_next   = wfull[57:15];
                            state_next = ST_ADD;
                        end
                    endcase
                end
            end
            ST_AMB:
            begin
                amb_next = prod[31:14];
                if (lit_reg)
                begin
                    state_next = ST_KD;
                end
                else
                begin
                    dif_next   = '0;
                    spe_next   = '0;
                    state_next = ST_ADD;
                end
            end
            ST_KD:
            begin
                kdc_next   = prod[31:15];
                state_next = ST_KS;
            end
            ST_KS:
            begin
                ksc_next   = prod[31:15];
                wa_next    = 42'(kdc_reg);
                wb_next    = 42'(dot_reg);
                acc_next   = '0;
                j_next     = 2'd0;
                op_next    = OP_DIF;
                state_next = ST_WMUL;
            end
            ST_ADD:
            begin
                sum_next[k_reg] = (tsum > 45'(SUM_MAX)) ? SUM_MAX : tsum[23:0];
                if (k_reg == 2'd2)
                begin
                    k_next     = 2'd0;
                    state_next = last_reg ? ST_FINISH : ST_IDLE;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_AMB;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_word_next.red_out   = sum_reg[0];
                    out_word_next.green_out = sum_reg[1];
                    out_word_next.blue_out  = sum_reg[2];
                    out_valid_next          = 1'b1;
                    for (int i = 0; i < 3; i++)
                    begin
                        sum_next[i] = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pass_reg      <= PASS_L;
            op_reg        <= OP_SQ;
            k_reg         <= 2'd0;
            cnt_reg       <= 5'd0;
            j_reg         <= 2'd0;
            ecnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            lit_reg       <= 1'b0;
            last_reg      <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            op_reg        <= op_next;
            k_reg         <= k_next;
            cnt_reg       <= cnt_next;
            j_reg         <= j_next;
            ecnt_reg      <= ecnt_next;
            out_valid_reg <= out_valid_next;
            lit_reg       <= lit_next;
            last_reg      <= last_next;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= sum_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            vec_reg[i]  <= vec_next[i];
            te_reg[i]   <= te_next[i];
            mag_reg[i]  <= mag_next[i];
            n_reg[i]    <= n_next[i];
            uvec_reg[i] <= uvec_next[i];
            lu_reg[i]   <= lu_next[i];
            eu_reg[i]   <= eu_next[i];
            hu_reg[i]   <= hu_next[i];
        end
        m_reg        <= m_next;
        sq_reg       <= sq_next;
        rem_reg      <= rem_next;
        res_reg      <= res_next;
        len_reg      <= len_next;
        dr_reg       <= dr_next;
        q_reg        <= q_next;
        dacc_reg     <= dacc_next;
        dot_reg      <= dot_next;
        base_reg     <= base_next;
        pr_reg       <= pr_next;
        exp_reg      <= exp_next;
        wa_reg       <= wa_next;
        wb_reg       <= wb_next;
        acc_reg      <= acc_next;
        amb_reg      <= amb_next;
        kdc_reg      <= kdc_next;
        ksc_reg      <= ksc_next;
        dif_reg      <= dif_next;
        spe_reg      <= spe_next;
        color_reg    <= color_next;
        out_word_reg <= out_word_next;
    end

endmodule

// File: hw/rtl/blinn_phong_vertex_shader_core.sv
// back end: one word at a time, paced by the bit-serial root and divide steps (four per
// unit vector) and the four partial products of each multiply in the power
// a two-word queue lets the input side keep taking words while the back end works, until it is full
// reset: asynchronous active low, clears sums, queue and coefficients, shininess to 1
`timescale 1ns / 1ps

module blinn_phong_vertex_shader_core
    import bpvs_pkg::*;
#(
    parameter int EXPONENT_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_word,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_word
);

    cfg_t         cfg_reg, cfg_next;
    logic         item_valid;
    item_t        item;
    back_status_t back_status;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_AMBIENT:   cfg_next.ambient_coeffs  = cfg_data;
                REG_DIFFUSE:   cfg_next.diffuse_coeffs  = cfg_data;
                REG_SPECULAR:  cfg_next.specular_coeffs = cfg_data;
                REG_SHININESS: cfg_next.shininess       = cfg_data[7:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ambient_coeffs  <= '0;
            cfg_reg.diffuse_coeffs  <= '0;
            cfg_reg.specular_coeffs <= '0;
            cfg_reg.shininess       <= SHININESS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bpvs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .item_valid (item_valid),
        .item       (item),
        .pop        (back_status.pop)
    );

    bpvs_back #(
        .EXPONENT_BITS (EXPONENT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .status     (back_status),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        back_status.pop |-> item_valid)
        else $error("back end popped an empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> item_valid)
        else $error("accepted word missing from queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(back_status.busy))
        else $error("result word without back end activity");
`endif

endmodule
